FILE: design/slt_pkg.sv
// shared types and constants of the sorted list table
`default_nettype none
package slt_pkg;

  localparam int KEY_BITS = 32;
  localparam int POS_BITS = 4;
  localparam int FILL_BITS = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_MODIFY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/slt_ifs.sv
// item channel interfaces of the sorted list table
`default_nettype none
interface slt_in_if
  import slt_pkg::*;
();
  logic                       valid;
  logic                       ready;
  kind_t                      kind;
  logic signed [KEY_BITS-1:0] search_key;
  logic signed [KEY_BITS-1:0] new_value;

  modport source (output valid, kind, search_key, new_value, input ready);
  modport sink (input valid, kind, search_key, new_value, output ready);
endinterface

interface slt_out_if
  import slt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [POS_BITS-1:0]  position;
  logic [FILL_BITS-1:0] fill_count;

  modport source (output valid, ok, position, fill_count, input ready);
  modport sink (input valid, ok, position, fill_count, output ready);
endinterface
`default_nettype wire

FILE: design/slt_cell.sv
// one slot of the sorted chain: compare against the operand, shift left or right
`default_nettype none
module slt_cell
  import slt_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire                         clk,
  input  cell_ctrl_t                  ctrl,
  input  wire                         occupied,
  input  wire signed [VALUE_BITS-1:0] operand,
  input  wire                         left_lt,
  input  wire signed [VALUE_BITS-1:0] left_value,
  input  wire signed [VALUE_BITS-1:0] right_value,
  output logic signed [VALUE_BITS-1:0] value_r,
  output logic                        lt,
  output logic                        boundary,
  output logic                        match
);

  logic signed [VALUE_BITS-1:0] value_nxt;

  assign lt       = occupied && (value_r < operand);
  assign boundary = left_lt && !lt;
  assign match    = boundary && occupied && (value_r == operand);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (!left_lt) begin
        value_nxt = left_value;
      end else if (!lt) begin
        value_nxt = operand;
      end
    end else if (ctrl.rem) begin
      if (!lt) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

FILE: design/sorted_list_table_unit.sv
// sorted list table: a chain of compare-and-shift cells under a small sequencer
//
// Keeps up to CAPACITY signed values in ascending order, duplicates allowed.
// in_ch carries one item per operation (insert, remove, find, modify) with
// valid/ready; out_ch returns exactly one result per item, in order, with
// ok, position and fill_count.
// Every cell compares its value with a broadcast operand in parallel and
// shifts to its neighbor. Insert, remove and find are accepted, then take
// one chain pass; modify, when its key is found, takes a remove pass, then
// an insert pass. The result is valid in the cycle after the last chain pass.
// in_ch.ready is high while the sequencer is idle, so an item can be taken
// while a result still waits in the output register.
// If out_ch stalls, a finished result holds in the output register and the
// next item waits in its final chain cycle until the register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; stored values are not cleared and are never read before written.
`default_nettype none
module sorted_list_table_unit
  import slt_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input wire        clk,
  input wire        rst_n,
  slt_in_if.sink    in_ch,
  slt_out_if.source out_ch
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  state_t                     state_r, state_nxt;
  kind_t                      kind_r;
  logic signed [KEY_BITS-1:0] key_r;
  logic signed [KEY_BITS-1:0] val_r;
  logic [CNT_BITS-1:0]        count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 ok_r;
  logic [POS_BITS-1:0]  pos_r;
  logic [FILL_BITS-1:0] fill_r;

  logic signed [VALUE_BITS-1:0] key_v, val_v, operand;
  cell_ctrl_t                   ctrl;
  logic                         result_we, res_ok;
  logic [IDX_BITS-1:0]          bpos, res_pos;
  logic                         found, full, out_free;

  logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]          cell_lt, cell_boundary, cell_match, cell_occ;

  assign key_v    = VALUE_BITS'(key_r);
  assign val_v    = VALUE_BITS'(val_r);
  assign full     = (count_r == CNT_BITS'(CAPACITY));
  assign out_free = !out_valid_r || out_ch.ready;
  assign operand  = (state_r == ST_SECOND || kind_r == KIND_INSERT) ? val_v : key_v;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         left_lt;
    logic signed [VALUE_BITS-1:0] left_value, right_value;

    assign cell_occ[i] = CNT_BITS'(i) < count_r;
    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = operand;
    end else begin : g_inner
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    slt_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cell_occ[i]),
      .operand    (operand),
      .left_lt    (left_lt),
      .left_value (left_value),
      .right_value(right_value),
      .value_r    (cell_value[i]),
      .lt         (cell_lt[i]),
      .boundary   (cell_boundary[i]),
      .match      (cell_match[i])
    );
  end

  always_comb begin
    bpos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_boundary[i]) begin
        bpos = bpos | IDX_BITS'(i);
      end
    end
  end

  assign found = |cell_match;

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ctrl      = '0;
    result_we = 1'b0;
    res_ok    = 1'b0;
    res_pos   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        case (kind_r)
          KIND_INSERT: begin
            if (out_free) begin
              ctrl.ins  = !full;
              result_we = 1'b1;
              res_ok    = !full;
              res_pos   = full ? '0 : bpos;
              count_nxt = full ? count_r : count_r + CNT_BITS'(1);
              state_nxt = ST_IDLE;
            end
          end
          KIND_REMOVE: begin
            if (out_free) begin
              ctrl.rem  = found;
              result_we = 1'b1;
              res_ok    = found;
              res_pos   = found ? bpos : '0;
              count_nxt = found ? count_r - CNT_BITS'(1) : count_r;
              state_nxt = ST_IDLE;
            end
          end
          KIND_FIND: begin
            if (out_free) begin
              result_we = 1'b1;
              res_ok    = found;
              res_pos   = found ? bpos : '0;
              state_nxt = ST_IDLE;
            end
          end
          KIND_MODIFY: begin
            if (found) begin
              ctrl.rem  = 1'b1;
              count_nxt = count_r - CNT_BITS'(1);
              state_nxt = ST_SECOND;
            end else if (out_free) begin
              result_we = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SECOND: begin
        if (out_free) begin
          ctrl.ins  = 1'b1;
          result_we = 1'b1;
          res_ok    = 1'b1;
          res_pos   = bpos;
          count_nxt = count_r + CNT_BITS'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result_we) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      key_r  <= in_ch.search_key;
      val_r  <= in_ch.new_value;
    end
    if (result_we) begin
      ok_r   <= res_ok;
      pos_r  <= POS_BITS'(res_pos);
      fill_r <= FILL_BITS'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.position   = pos_r;
  assign out_ch.fill_count = fill_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  a_boundary_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_boundary))
    else $error("more than one insertion boundary");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    result_we && res_ok |->
      (CNT_BITS'(res_pos) < count_r || CNT_BITS'(res_pos) < count_nxt))
    else $error("reported position beyond stored values");

  a_second_after_modify: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SECOND |->
      ($past(state_r) == ST_FIRST || $past(state_r) == ST_SECOND) &&
      kind_r == KIND_MODIFY)
    else $error("insert pass without a modify removal");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) != ST_IDLE)
    else $error("result raised without an item at work");

endmodule
`default_nettype wire
